// ----- design/mlf_pkg.sv -----
package mlf_pkg;

  localparam int PULSE_SLOTS_DEF = 11;
  localparam int MS_PER_UNIT_DEF = 10;

  localparam int CHAR_W  = 8;
  localparam int TIME_W  = 32;
  localparam int PULSE_W = 7;
  localparam int FILL_W  = 4;
  localparam int LEN_W   = 3;
  localparam int ELEM_MAX = 5;

  localparam logic [PULSE_W-1:0] DOT_UNITS    = 7'd20;
  localparam logic [PULSE_W-1:0] DASH_UNITS   = 7'd60;
  localparam logic [PULSE_W-1:0] GAP_UNITS    = 7'd20;
  localparam logic [PULSE_W-1:0] LETTER_UNITS = 7'd100;
  localparam logic [PULSE_W-1:0] RESET_UNITS  = 7'd10;
  localparam logic [PULSE_W-1:0] END_UNITS    = 7'd0;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FILL,
    ST_READ,
    ST_MUL,
    ST_CMP_DL,
    ST_CMP_WRAP,
    ST_UPD,
    ST_DONE
  } state_t;

  // One Morse character: element count and a dash mask, element 0 in bit 0.
  typedef struct packed {
    logic                found;
    logic [LEN_W-1:0]    len;
    logic [ELEM_MAX-1:0] dash;
  } code_t;

  function automatic code_t char_lookup(input logic [CHAR_W-1:0] ch);
    code_t c;
    c = '{found: 1'b1, len: 3'd0, dash: 5'b00000};
    case (ch)
      8'h42: begin c.len = 3'd4; c.dash = 5'b00001; end // B -...
      8'h43: begin c.len = 3'd4; c.dash = 5'b00101; end // C -.-.
      8'h50: begin c.len = 3'd4; c.dash = 5'b00110; end // P .--.
      8'h54: begin c.len = 3'd1; c.dash = 5'b00001; end // T -
      8'h30: begin c.len = 3'd5; c.dash = 5'b11111; end // 0
      8'h31: begin c.len = 3'd5; c.dash = 5'b11110; end // 1
      8'h32: begin c.len = 3'd5; c.dash = 5'b11100; end // 2
      8'h33: begin c.len = 3'd5; c.dash = 5'b11000; end // 3
      8'h34: begin c.len = 3'd5; c.dash = 5'b10000; end // 4
      8'h35: begin c.len = 3'd5; c.dash = 5'b00000; end // 5
      8'h36: begin c.len = 3'd5; c.dash = 5'b00001; end // 6
      8'h37: begin c.len = 3'd5; c.dash = 5'b00011; end // 7
      8'h38: begin c.len = 3'd5; c.dash = 5'b00111; end // 8
      8'h39: begin c.len = 3'd5; c.dash = 5'b01111; end // 9
      default: c.found = 1'b0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/mlf_if.sv -----
interface mlf_in_if import mlf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAR_W-1:0] char_code;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, func, char_code, now_ms, input ready);
  modport sink   (input valid, func, char_code, now_ms, output ready);
endinterface

interface mlf_out_if ();
  logic valid;
  logic ready;
  logic led_on;
  logic not_found;

  modport source (output valid, led_on, not_found, input ready);
  modport sink   (input valid, led_on, not_found, output ready);
endinterface

// ----- design/morse_led_flasher.sv -----
// A tick transaction reads its slot, scales it to ms, checks the deadline and the wrap,
// then updates the slot; a set transaction with a new known character fills two slots
// per Morse element (n elements, at most 5) plus a terminator, and a repeated or unknown
// character goes straight to done. One item at a time; a held result adds its stall.
// Rate is set by the shared deadline compare unit and by the one-slot-per-cycle fill.
// Reset (rst, synchronous): all pulse slots 10, slot 0, LED off, start time 0.
module morse_led_flasher import mlf_pkg::*; #(
  parameter int PULSE_SLOTS = PULSE_SLOTS_DEF,
  parameter int MS_PER_UNIT = MS_PER_UNIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mlf_in_if.sink    item,
  mlf_out_if.source result
);

  localparam int IDX_W  = $clog2(PULSE_SLOTS);
  localparam int PROD_W = $clog2(MS_PER_UNIT * ((1 << PULSE_W) - 1) + 1);

  state_t state, state_next;

  // Captured transaction
  logic              func;
  logic [CHAR_W-1:0] char_code;
  logic [TIME_W-1:0] now_ms;

  // Beacon state
  logic [CHAR_W-1:0] beacon_char;
  logic [IDX_W-1:0]  slot_index;
  logic [TIME_W-1:0] slot_start;
  logic              led_level;

  // Working registers
  code_t             code;
  logic [FILL_W-1:0] fill_cnt;
  logic [PROD_W-1:0] prod;
  logic              p_zero;
  logic              dl_hit;
  logic              missing;

  // Output register
  logic out_valid;
  logic out_led;
  logic out_nf;

  // Store and compare unit hookup
  logic               st_wr_en;
  logic [PULSE_W-1:0] st_wr_data;
  logic [PULSE_W-1:0] st_rd_data;
  logic [TIME_W-1:0]  cmp_offset;
  logic               cmp_ge;

  logic [FILL_W-1:0]  fill_last;
  logic               advance;
  logic [IDX_W:0]     idx_inc;
  logic [IDX_W-1:0]   idx_next;
  code_t              lookup;

  mlf_store #(.SLOTS(PULSE_SLOTS), .IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (st_wr_en),
    .wr_idx  (IDX_W'(fill_cnt)),
    .wr_data (st_wr_data),
    .rd_idx  (slot_index),
    .rd_data (st_rd_data)
  );

  mlf_cmp u_cmp (
    .clk    (clk),
    .base   (slot_start),
    .offset (cmp_offset),
    .probe  (now_ms),
    .ge     (cmp_ge)
  );

  assign lookup    = char_lookup(char_code);
  // Terminator slot sits right after the last gap: two slots per element.
  assign fill_last = {code.len, 1'b0};

  // Advance when the deadline has passed or time has wrapped below the slot start
  // (the compare unit holds now >= start in ST_UPD).
  assign advance  = dl_hit || !cmp_ge;
  assign idx_inc  = {1'b0, slot_index} + (IDX_W+1)'(1);
  assign idx_next = (idx_inc == (IDX_W+1)'(PULSE_SLOTS)) ? '0 : idx_inc[IDX_W-1:0];

  assign item.ready       = (state == ST_IDLE);
  assign result.valid     = out_valid;
  assign result.led_on    = out_led;
  assign result.not_found = out_nf;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = (item.func == FUNC_SET) ? ST_LOOK : ST_READ;
        end
      end
      ST_LOOK: begin
        // Same character or unknown one: nothing to load
        if (char_code != beacon_char && lookup.found) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fill_cnt == fill_last) begin
          state_next = ST_DONE;
        end
      end
      ST_READ:     state_next = ST_MUL;
      ST_MUL:      state_next = ST_CMP_DL;
      ST_CMP_DL:   state_next = ST_CMP_WRAP;
      ST_CMP_WRAP: state_next = ST_UPD;
      ST_UPD:      state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_data = GAP_UNITS;
    cmp_offset = '0;
    unique case (state)
      ST_FILL: begin
        st_wr_en = 1'b1;
        if (fill_cnt == fill_last) begin
          st_wr_data = END_UNITS;
        end else if (fill_cnt == fill_last - FILL_W'(1)) begin
          st_wr_data = LETTER_UNITS;
        end else if (fill_cnt[0]) begin
          st_wr_data = GAP_UNITS;
        end else begin
          st_wr_data = code.dash[fill_cnt[FILL_W-1:1]] ? DASH_UNITS : DOT_UNITS;
        end
      end
      ST_CMP_DL: cmp_offset = TIME_W'(prod);
      default: begin
        st_wr_en = 1'b0;
      end
    endcase
  end

  // Control and beacon state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      beacon_char <= '0;
      slot_index  <= '0;
      slot_start  <= '0;
      led_level   <= 1'b0;
      out_valid   <= 1'b0;
      fill_cnt    <= '0;
    end else begin
      state <= state_next;
      // Load a new result in ST_DONE once the register is free, else drop it once taken
      if (state == ST_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: fill_cnt <= '0;
        ST_FILL: begin
          fill_cnt <= fill_cnt + FILL_W'(1);
          if (fill_cnt == fill_last) begin
            // Restart the pattern: slot 0 always holds an element, so LED on
            beacon_char <= char_code;
            slot_index  <= '0;
            slot_start  <= now_ms;
            led_level   <= 1'b1;
          end
        end
        ST_UPD: begin
          if (p_zero) begin
            slot_index <= '0;
          end else if (advance) begin
            slot_index <= idx_next;
            slot_start <= now_ms;
            led_level  <= !idx_next[0];
          end
        end
        default: begin
          fill_cnt <= fill_cnt;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      func      <= item.func;
      char_code <= item.char_code;
      now_ms    <= item.now_ms;
      missing   <= 1'b0;
    end
    if (state == ST_LOOK) begin
      code    <= lookup;
      missing <= (char_code != beacon_char) && !lookup.found;
    end
    if (state == ST_MUL) begin
      prod   <= PROD_W'(MS_PER_UNIT) * PROD_W'(st_rd_data);
      p_zero <= (st_rd_data == END_UNITS);
    end
    if (state == ST_CMP_WRAP) begin
      dl_hit <= cmp_ge;
    end
    if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_led <= led_level;
      out_nf  <= missing && (func == FUNC_SET);
    end
  end

  // Checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot_index} < (IDX_W+1)'(PULSE_SLOTS))
    else $error("slot index out of range");

  a_accept_route: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> (state == ST_LOOK || state == ST_READ))
    else $error("accepted transaction did not start work");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> fill_cnt <= fill_last)
    else $error("store fill ran past terminator");

  a_led_parity: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD && !p_zero && advance |=> led_level == !slot_index[0])
    else $error("LED level does not follow slot parity");

endmodule

// ----- design/mlf_store.sv -----
module mlf_store import mlf_pkg::*; #(
  parameter int SLOTS = PULSE_SLOTS_DEF,
  parameter int IDX_W = $clog2(PULSE_SLOTS_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [PULSE_W-1:0] wr_data,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [PULSE_W-1:0] rd_data
);

  logic [PULSE_W-1:0] slots [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= RESET_UNITS;
      end
    end else if (wr_en) begin
      slots[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= slots[rd_idx];
  end

endmodule

// ----- design/mlf_cmp.sv -----
module mlf_cmp import mlf_pkg::*; (
  input  logic              clk,
  input  logic [TIME_W-1:0] base,
  input  logic [TIME_W-1:0] offset,
  input  logic [TIME_W-1:0] probe,
  output logic              ge
);

  // Sum keeps the carry, so a deadline past the top of the time range is never reached.
  logic [TIME_W:0] sum;

  assign sum = {1'b0, base} + {1'b0, offset};

  always_ff @(posedge clk) begin
    ge <= ({1'b0, probe} >= sum);
  end

endmodule

// ----- tb/morse_led_flasher_tb.sv -----
`timescale 1ns / 100ps

// Checks the Morse beacon keyer one transaction at a time. A local model of
// the pulse store, slot pointer, slot start time and LED level predicts the
// result of every accepted item, and the result stream is compared against it.
// Both channels idle at random, and one long result stall backs up the input.
module morse_led_flasher_tb;
  import mlf_pkg::*;

  localparam int SLOTS       = PULSE_SLOTS_DEF;
  localparam int UNIT_MS     = MS_PER_UNIT_DEF;
  localparam int HOLD_CYCLES = 300;   // long result stall for the pressure phase
  localparam int STALL_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 20;    // margin after the drain, more than a set with five elements needs

  typedef struct packed {
    logic led_on;
    logic not_found;
  } flash_t;

  logic clk = 1'b0;
  logic rst;

  mlf_in_if  item_bus ();
  mlf_out_if result_bus ();

  morse_led_flasher #(
    .PULSE_SLOTS(SLOTS),
    .MS_PER_UNIT(UNIT_MS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local keyer state, kept at the block's widths.
  logic [PULSE_W-1:0] pulse_units [SLOTS];
  logic [3:0]         slot_ptr;
  logic [TIME_W-1:0]  slot_t0;
  logic [CHAR_W-1:0]  shown_char;
  logic               lamp;

  string  beacon_chars = "BCPT0123456789";
  flash_t flash_q[$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  missing_count = 0;
  int  slot_moves    = 0;
  bit  no_idle       = 1'b0;  // when set, neither side inserts gaps
  bit  hold_request  = 1'b0;  // raised by a test, consumed by the result sink

  // Return the dot/dash text of a beacon character, empty if it is not one.
  function automatic string morse_of(input logic [CHAR_W-1:0] ch);
    case (ch)
      "B": return "-...";
      "C": return "-.-.";
      "P": return ".--.";
      "T": return "-";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      default: return "";
    endcase
  endfunction

  // Fold a slot position past the end of the store back to slot 0.
  function automatic int slot_of(input int pos);
    return (pos < SLOTS) ? pos : 0;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_keyer();
    for (int i = 0; i < SLOTS; i++) pulse_units[i] = RESET_UNITS;
    slot_ptr   = '0;
    slot_t0    = '0;
    shown_char = '0;
    lamp       = 1'b0;
  endtask

  // Advance to the next slot once its time is up or the clock has wrapped;
  // a terminator slot sends the pointer home and leaves the LED alone.
  task automatic step_slot(input logic [TIME_W-1:0] now);
    int                 idx;
    logic [PULSE_W-1:0] units;
    logic [63:0]        deadline;
    idx   = slot_of(int'(slot_ptr));
    units = pulse_units[idx];
    if (units != END_UNITS) begin
      // no 32-bit wrap on the deadline: a slot started near the top ends at wrap
      deadline = 64'(slot_t0) + 64'(UNIT_MS) * 64'(units);
      if (64'(now) >= deadline || now < slot_t0) begin
        idx      = slot_of(idx + 1);
        slot_ptr = 4'(idx);
        slot_t0  = now;
        lamp     = (idx % 2 == 0);
        slot_moves++;
      end
    end else begin
      slot_ptr = '0;
    end
  endtask

  // Work out the result of one accepted transaction and queue it.
  task automatic predict_flash(input logic f, input logic [CHAR_W-1:0] ch,
                               input logic [TIME_W-1:0] now);
    string  code;
    int     pos;
    flash_t want;
    want.not_found = 1'b0;
    if (f == FUNC_SET) begin
      // the same character again changes nothing
      if (ch != shown_char) begin
        code = morse_of(ch);
        if (code.len() == 0) begin
          want.not_found = 1'b1;
          missing_count++;
        end else begin
          // element, gap, element, gap ... last gap becomes the letter gap
          pos = 0;
          for (int k = 0; k < code.len() && k < ELEM_MAX; k++) begin
            pulse_units[slot_of(pos)] = (code[k] == ".") ? DOT_UNITS : DASH_UNITS;
            pos++;
            pulse_units[slot_of(pos)] = GAP_UNITS;
            pos++;
          end
          if (pos > 0) pulse_units[slot_of(pos - 1)] = LETTER_UNITS;
          pulse_units[slot_of(pos)] = END_UNITS;
          shown_char = ch;
          slot_ptr   = '0;
          slot_t0    = now;
          lamp       = (pulse_units[0] != END_UNITS);
          step_slot(now);
        end
      end
    end else begin
      step_slot(now);
    end
    want.led_on = lamp;
    flash_q.push_back(want);
  endtask

  // Offer one transaction, with an optional gap first; predict on acceptance.
  // Valid stays high after acceptance until the next falling edge decides.
  task automatic send_item(input logic f, input logic [CHAR_W-1:0] ch,
                           input logic [TIME_W-1:0] now);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      item_bus.valid <= 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.func      <= f;
    item_bus.char_code <= ch;
    item_bus.now_ms    <= now;
    do @(posedge clk); while (!item_bus.ready);
    predict_flash(f, ch, now);
    items_sent++;
  endtask

  // Reset store: every slot is 10 units with no terminator, so the pointer
  // runs off the end and wraps to slot 0. Character zero matches the reset
  // character and is treated as a repeat.
  task automatic test_reset_store();
    send_item(FUNC_SET, 8'h00, 32'd0);
    send_item(FUNC_TICK, 8'h00, 32'd0);
    for (int k = 1; k <= 12; k++) send_item(FUNC_TICK, 8'h00, 32'(100 * k));
  endtask

  // Deadline across the top of the time range, the terminator slot, a
  // repeated character, unknown characters, and a tick carrying a character.
  task automatic test_edge_cases();
    send_item(FUNC_SET, "T", 32'hFFFF_FFF6);
    send_item(FUNC_TICK, 8'h00, 32'hFFFF_FFFF);  // not due yet
    send_item(FUNC_TICK, 8'h00, 32'd5);          // clock wrapped: advance
    send_item(FUNC_TICK, 8'h00, 32'd1005);       // letter gap done
    send_item(FUNC_TICK, 8'h00, 32'd1006);       // terminator: back to slot 0
    send_item(FUNC_SET, "T", 32'd2000);
    send_item(FUNC_SET, 8'hFF, 32'd2001);
    send_item(FUNC_SET, 8'h00, 32'd2002);
    send_item(FUNC_TICK, 8'hFF, 32'd1100);
  endtask

  // Mostly a running beacon: ticks with a clock that creeps forward at about
  // slot pace, plus character changes; the rest is repeats, junk characters,
  // time jumps and runs near the wrap. One long result stall backs up the
  // input, and a stretch runs with no gaps on either side.
  task automatic test_random_beacon(input int count);
    logic [TIME_W-1:0] clock_ms;
    int                pick;
    clock_ms = $urandom;
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) hold_request = 1'b1;
      no_idle = (k >= count / 2 && k < count / 2 + count / 6);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        clock_ms += $urandom_range(0, 700);
        send_item(FUNC_TICK, 8'($urandom), clock_ms);
      end else if (pick < 80) begin
        clock_ms += $urandom_range(0, 50);
        send_item(FUNC_SET, beacon_chars[$urandom_range(0, 13)], clock_ms);
      end else if (pick < 85) begin
        send_item(FUNC_SET, shown_char, clock_ms);
      end else if (pick < 91) begin
        send_item(FUNC_SET, 8'($urandom), clock_ms);
      end else if (pick < 96) begin
        clock_ms = $urandom;
        send_item(FUNC_TICK, 8'($urandom), clock_ms);
      end else begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);
        send_item(FUNC_TICK, 8'($urandom), clock_ms);
      end
    end
    no_idle = 1'b0;
  endtask

  // Result sink: random stalls, one long hold on request, and full speed
  // whenever the no-idle stretch is on.
  initial begin : result_sink
    result_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
    end
  end

  // Compare each result transaction against the oldest prediction.
  always @(posedge clk) begin : result_check
    flash_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (flash_q.size() == 0) begin
        $error("result with nothing pending: led_on=%0b not_found=%0b",
               result_bus.led_on, result_bus.not_found);
        errors++;
      end else begin
        want = flash_q.pop_front();
        if (result_bus.led_on !== want.led_on) begin
          $error("led_on: expected %0b, got %0b", want.led_on, result_bus.led_on);
          errors++;
        end
        if (result_bus.not_found !== want.not_found) begin
          $error("not_found: expected %0b, got %0b", want.not_found,
                 result_bus.not_found);
          errors++;
        end
        results_seen++;
      end
    end
  end

  // Watchdog: drop out if no transaction moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no transaction for %0d cycles, %0d results pending", STALL_LIMIT,
           flash_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run
    int waited;
    rst                <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.func      <= FUNC_TICK;
    item_bus.char_code <= '0;
    item_bus.now_ms    <= '0;
    clear_keyer();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_reset_store();
    test_edge_cases();
    test_random_beacon(900);

    // Drop valid, drain what is pending, then wait out the tail margin.
    @(negedge clk);
    item_bus.valid <= 1'b0;
    waited = 0;
    while (flash_q.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (flash_q.size() != 0) begin
      $error("%0d results never arrived", flash_q.size());
      errors++;
    end

    $display("Run: %0d items sent, %0d results checked, %0d unknown characters,",
             items_sent, results_seen, missing_count);
    $display("     %0d slot advances, one %0d-cycle result stall.", slot_moves,
             HOLD_CYCLES);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mlf_pkg.sv
design/mlf_if.sv
design/mlf_store.sv
design/mlf_cmp.sv
design/morse_led_flasher.sv
tb/morse_led_flasher_tb.sv
